@@ src/quoted_token_unquoter_macros.svh @@
// Assertion macros for the quoted token unquoter checker.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef QUOTED_TOKEN_UNQUOTER_MACROS_SVH
`define QUOTED_TOKEN_UNQUOTER_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define QTU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define QTU_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ src/qtu_pkg.sv @@
// Shared types, constants and helpers of the quoted token unquoter.
// Used by the front, queue, back and top level; depends on nothing.
package qtu_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int NEXT_OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic                        emit_bs;
    logic                        emit_byte;
    logic                        has_term;
    logic                        term_err;
    logic [7:0]                  data;
    logic [NEXT_OFFSET_BITS-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

@@ src/quoted_token_unquoter.sv @@
// Quoted token unquoter top level: front, command queue and back.
// Depends on qtu_pkg, qtu_front, qtu_queue and qtu_back.
//
// The input channel takes one text byte per request with first_byte marking
// the start of an extraction and end_of_text marking the last byte. A quoted
// token (opening single quote) yields its content with backslash-quote turned
// into a bare quote; an unquoted token yields its run of non-whitespace bytes.
// The output channel carries content bytes (kind 0), then one finish (kind 1,
// with the offset just past the token) or one missing-quote error (kind 2),
// flagged by last.
// A byte's command passes through the queue and its results through the
// output register. One result leaves per cycle unless the receiver stalls,
// and the block takes one byte per cycle while the queue has room; a byte
// that yields two or three results (escapes, end of text) holds the back
// longer and the two-entry queue absorbs the difference.
// When the receiver stalls, the output register holds its result, the queue
// fills and the input stall rises once it is full.
// Reset clears the mode to idle, the offset, the queue and the output valid.
module quoted_token_unquoter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 first_byte_i,
  input  logic                                 end_of_text_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           out_byte_o,
  output logic [1:0]                           kind_o,
  output logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] next_offset_o,
  output logic                                 last_o
);

  logic                   push, pop;
  qtu_pkg::cmd_t          cmd, head;
  qtu_pkg::queue_status_t status;

  qtu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (data_byte_i),
    .first_i (first_byte_i),
    .eot_i   (end_of_text_i),
    .full_i  (status.full),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  qtu_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  qtu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (status),
    .pop_o         (pop),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .next_offset_o (next_offset_o),
    .last_o        (last_o)
  );

endmodule

@@ src/qtu_front.sv @@
// Front part of the quoted token unquoter: accepts text bytes, tracks the
// extraction mode and offset, and turns each byte into a result command.
// Depends on qtu_pkg.
module qtu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [7:0]                  data_i,
  input  logic                        first_i,
  input  logic                        eot_i,
  input  logic                        full_i,
  output logic                        push_o,
  output qtu_pkg::cmd_t               cmd_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_TOKEN,
    MODE_QUOTED,
    MODE_ESCAPE,
    MODE_DONE
  } mode_e;

  mode_e                           mode_q, mode_d;
  logic [qtu_pkg::OFFSET_BITS-1:0] off_q, off_d, off_inc;
  logic                            accept;
  qtu_pkg::cmd_t                   cmd;

  assign accept  = valid_i & ~full_i;
  assign stall_o = full_i;
  assign off_inc = (off_q == qtu_pkg::OFFSET_MAX) ? off_q : off_q + 1'b1;

  always_comb begin
    mode_d = mode_q;
    off_d  = off_q;
    cmd    = '0;
    cmd.data = data_i;
    if (accept) begin
      if (first_i) begin
        off_d = '0;
        if (data_i == qtu_pkg::CH_QUOTE) begin
          off_d  = qtu_pkg::OFFSET_BITS'(1);
          mode_d = MODE_QUOTED;
          if (eot_i) begin
            cmd.has_term = 1'b1;
            cmd.term_err = 1'b1;
            mode_d = MODE_DONE;
          end
        end else if (qtu_pkg::is_space(data_i)) begin
          cmd.has_term = 1'b1;
          mode_d = MODE_DONE;
        end else begin
          cmd.emit_byte = 1'b1;
          off_d  = qtu_pkg::OFFSET_BITS'(1);
          mode_d = MODE_TOKEN;
          if (eot_i) begin
            cmd.has_term = 1'b1;
            cmd.offset   = qtu_pkg::NEXT_OFFSET_BITS'(off_d);
            mode_d = MODE_DONE;
          end
        end
      end else begin
        case (mode_q)
          MODE_TOKEN: begin
            if (qtu_pkg::is_space(data_i)) begin
              cmd.has_term = 1'b1;
              cmd.offset   = qtu_pkg::NEXT_OFFSET_BITS'(off_q);
              mode_d = MODE_DONE;
            end else begin
              cmd.emit_byte = 1'b1;
              off_d = off_inc;
              if (eot_i) begin
                cmd.has_term = 1'b1;
                cmd.offset   = qtu_pkg::NEXT_OFFSET_BITS'(off_inc);
                mode_d = MODE_DONE;
              end
            end
          end
          MODE_QUOTED: begin
            off_d = off_inc;
            if (data_i == qtu_pkg::CH_QUOTE) begin
              cmd.has_term = 1'b1;
              cmd.offset   = qtu_pkg::NEXT_OFFSET_BITS'(off_inc);
              mode_d = MODE_DONE;
            end else begin
              if (data_i == qtu_pkg::CH_BACKSLASH) begin
                mode_d = MODE_ESCAPE;
              end else begin
                cmd.emit_byte = 1'b1;
              end
              if (eot_i) begin
                cmd.has_term = 1'b1;
                cmd.term_err = 1'b1;
                mode_d = MODE_DONE;
              end
            end
          end
          MODE_ESCAPE: begin
            off_d = off_inc;
            cmd.emit_bs   = (data_i != qtu_pkg::CH_QUOTE);
            cmd.emit_byte = 1'b1;
            mode_d = MODE_QUOTED;
            if (eot_i) begin
              cmd.has_term = 1'b1;
              cmd.term_err = 1'b1;
              mode_d = MODE_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign push_o = accept & (cmd.emit_bs | cmd.emit_byte | cmd.has_term);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      off_q  <= '0;
    end else begin
      mode_q <= mode_d;
      off_q  <= off_d;
    end
  end

endmodule

@@ src/qtu_queue.sv @@
// Short command queue between the front and the back of the unquoter.
// Depends on qtu_pkg.
module qtu_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  qtu_pkg::cmd_t          cmd_i,
  input  logic                   pop_i,
  output qtu_pkg::cmd_t          head_o,
  output qtu_pkg::queue_status_t status_o
);

  qtu_pkg::cmd_t                 mem_q [qtu_pkg::QUEUE_DEPTH];
  logic [qtu_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [qtu_pkg::QCNT_BITS-1:0] count_q;
  logic                          do_push, do_pop;

  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == qtu_pkg::QCNT_BITS'(qtu_pkg::QUEUE_DEPTH));
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & status_o.valid;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/qtu_back.sv @@
// Back of the unquoter: expands queued commands into result items, one per
// cycle unless stalled, through an output register. Depends on qtu_pkg.
module qtu_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qtu_pkg::cmd_t                        head_i,
  input  qtu_pkg::queue_status_t               status_i,
  output logic                                 pop_o,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [7:0]                           out_byte_o,
  output logic [1:0]                           kind_o,
  output logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] next_offset_o,
  output logic                                 last_o
);

  qtu_pkg::cmd_t                        cur_q, cur_d, src, rest;
  logic                                 cur_pend, src_valid, advance;
  logic                                 valid_q;
  logic [7:0]                           byte_q, byte_d;
  qtu_pkg::kind_e                       kind_q, kind_d;
  logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] off_q, off_d;
  logic                                 last_q, last_d;

  assign cur_pend  = cur_q.emit_bs | cur_q.emit_byte | cur_q.has_term;
  assign src       = cur_pend ? cur_q : head_i;
  assign src_valid = cur_pend | status_i.valid;
  assign advance   = src_valid & (~valid_q | ~stall_i);
  assign pop_o     = advance & ~cur_pend;

  always_comb begin
    rest   = src;
    byte_d = '0;
    kind_d = qtu_pkg::KIND_DATA;
    off_d  = '0;
    last_d = 1'b0;
    if (src.emit_bs) begin
      byte_d = qtu_pkg::CH_BACKSLASH;
      rest.emit_bs = 1'b0;
    end else if (src.emit_byte) begin
      byte_d = src.data;
      rest.emit_byte = 1'b0;
    end else begin
      last_d = 1'b1;
      rest.has_term = 1'b0;
      if (src.term_err) begin
        kind_d = qtu_pkg::KIND_ERROR;
      end else begin
        kind_d = qtu_pkg::KIND_FINISH;
        off_d  = src.offset;
      end
    end
    cur_d = advance ? rest : cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cur_q <= cur_d;
      if (advance) begin
        valid_q <= 1'b1;
      end else if (!stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      kind_q <= kind_d;
      off_q  <= off_d;
      last_q <= last_d;
    end
  end

  assign valid_o       = valid_q;
  assign out_byte_o    = byte_q;
  assign kind_o        = kind_q;
  assign next_offset_o = off_q;
  assign last_o        = last_q;

endmodule

@@ src/qtu_checker.sv @@
// Port-level checker for the quoted token unquoter, bound to the top level.
// Depends on qtu_pkg and quoted_token_unquoter_macros.svh.
`include "quoted_token_unquoter_macros.svh"

module qtu_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_i,
  input logic                                 out_stall_i,
  input logic [7:0]                           out_byte_i,
  input logic [1:0]                           kind_i,
  input logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] next_offset_i,
  input logic                                 last_i
);

  `QTU_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_byte_i) && $stable(kind_i) && $stable(next_offset_i) && $stable(last_i), "Stalled result changed.")
  `QTU_ASSERT_ALWAYS(a_kind_code, !out_valid_i || kind_i != 2'd3, "Undefined result kind.")
  `QTU_ASSERT_ALWAYS(a_last_on_end, !out_valid_i || (last_i == (kind_i != qtu_pkg::KIND_DATA)), "Last flag does not match the result kind.")
  `QTU_ASSERT_ALWAYS(a_offset_zero, !out_valid_i || kind_i == qtu_pkg::KIND_FINISH || next_offset_i == '0, "Offset set on a result that is not a finish.")
  `QTU_ASSERT_ALWAYS(a_byte_zero, !out_valid_i || kind_i == qtu_pkg::KIND_DATA || out_byte_i == 8'd0, "Byte set on a result that is not content.")

endmodule

bind quoted_token_unquoter qtu_checker u_qtu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_i    (out_byte_o),
  .kind_i        (kind_o),
  .next_offset_i (next_offset_o),
  .last_i        (last_o)
);

@@ sim/qtu_checker.sv @@
// Watches both channels of the quoted token unquoter, predicts each result
// from the accepted text bytes and compares it field by field.
// Depends on qtu_pkg for the kind codes, the character codes and the widths.
module qtu_tb_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 first_byte_i,
  input  logic                                 end_of_text_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [7:0]                           out_byte_i,
  input  logic [1:0]                           kind_i,
  input  logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] next_offset_i,
  input  logic                                 last_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TOKEN,
    SCAN_QUOTED,
    SCAN_ESCAPE,
    SCAN_DONE
  } scan_e;

  typedef struct packed {
    logic [7:0]                           text;
    qtu_pkg::kind_e                       kind;
    logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] offset;
    logic                                 last;
  } unquoted_t;

  unquoted_t                       expected_results[$];
  scan_e                           scan_mode;
  logic [qtu_pkg::OFFSET_BITS-1:0] consumed;

  function automatic logic blank(input logic [7:0] b);
    case (b)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(input logic [7:0] text, input qtu_pkg::kind_e kind);
    unquoted_t r;
    r.text   = (kind == qtu_pkg::KIND_DATA) ? text : 8'h00;
    r.kind   = kind;
    r.offset = (kind == qtu_pkg::KIND_FINISH) ?
               qtu_pkg::NEXT_OFFSET_BITS'(consumed) : '0;
    r.last   = (kind != qtu_pkg::KIND_DATA);
    expected_results.push_back(r);
  endfunction

  function automatic void advance();
    if (consumed != qtu_pkg::OFFSET_MAX) begin
      consumed = consumed + 1'b1;
    end
  endfunction

  function automatic void unquote_byte(input logic [7:0] b, input logic first,
                                       input logic eot);
    if (first) begin
      consumed = '0;
      if (b == qtu_pkg::CH_QUOTE) begin
        consumed  = qtu_pkg::OFFSET_BITS'(1);
        scan_mode = SCAN_QUOTED;
        if (eot) begin
          emit(8'h00, qtu_pkg::KIND_ERROR);
          scan_mode = SCAN_DONE;
        end
      end else if (blank(b)) begin
        emit(8'h00, qtu_pkg::KIND_FINISH);
        scan_mode = SCAN_DONE;
      end else begin
        emit(b, qtu_pkg::KIND_DATA);
        consumed  = qtu_pkg::OFFSET_BITS'(1);
        scan_mode = SCAN_TOKEN;
        if (eot) begin
          emit(8'h00, qtu_pkg::KIND_FINISH);
          scan_mode = SCAN_DONE;
        end
      end
      return;
    end
    case (scan_mode)
      SCAN_TOKEN: begin
        if (blank(b)) begin
          emit(8'h00, qtu_pkg::KIND_FINISH);
          scan_mode = SCAN_DONE;
        end else begin
          emit(b, qtu_pkg::KIND_DATA);
          advance();
          if (eot) begin
            emit(8'h00, qtu_pkg::KIND_FINISH);
            scan_mode = SCAN_DONE;
          end
        end
      end
      SCAN_QUOTED: begin
        advance();
        if (b == qtu_pkg::CH_QUOTE) begin
          emit(8'h00, qtu_pkg::KIND_FINISH);
          scan_mode = SCAN_DONE;
        end else begin
          if (b == qtu_pkg::CH_BACKSLASH) begin
            scan_mode = SCAN_ESCAPE;
          end else begin
            emit(b, qtu_pkg::KIND_DATA);
          end
          if (eot) begin
            emit(8'h00, qtu_pkg::KIND_ERROR);
            scan_mode = SCAN_DONE;
          end
        end
      end
      SCAN_ESCAPE: begin
        advance();
        if (b != qtu_pkg::CH_QUOTE) begin
          emit(qtu_pkg::CH_BACKSLASH, qtu_pkg::KIND_DATA);
        end
        emit(b, qtu_pkg::KIND_DATA);
        scan_mode = SCAN_QUOTED;
        if (eot) begin
          emit(8'h00, qtu_pkg::KIND_ERROR);
          scan_mode = SCAN_DONE;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    unquoted_t want;
    if (!rst_ni) begin
      scan_mode = SCAN_IDLE;
      consumed  = '0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        unquote_byte(data_byte_i, first_byte_i, end_of_text_i);
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $error("result with nothing expected: kind %0d, out_byte %0h",
                 kind_i, out_byte_i);
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", want.text, out_byte_i);
          check_field("kind", want.kind, kind_i);
          check_field("next_offset", want.offset, next_offset_i);
          check_field("last", want.last, last_i);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ sim/quoted_token_unquoter_tb.sv @@
// Top of the quoted token unquoter testbench: clock, reset, text stimulus
// and receiver stalls. Depends on qtu_pkg, the block and qtu_tb_checker.
module quoted_token_unquoter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [7:0]                           data_byte_i;
  logic                                 first_byte_i;
  logic                                 end_of_text_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic [7:0]                           out_byte_o;
  logic [1:0]                           kind_o;
  logic [qtu_pkg::NEXT_OFFSET_BITS-1:0] next_offset_o;
  logic                                 last_o;

  int fail_count;
  int pending;
  int checked;
  int burst_left;
  int bytes_sent;
  int extractions;
  int stall_style;
  int stall_left;

  quoted_token_unquoter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .next_offset_o (next_offset_o),
    .last_o        (last_o)
  );

  qtu_tb_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_i    (out_byte_o),
    .kind_i        (kind_o),
    .next_offset_i (next_offset_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver picks one of four stall styles and switches between them.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ((stall_left % 12) < 7);
    endcase
  end

  function automatic logic [7:0] solid_byte();
    int r;
    r = $urandom_range(0, 249);
    if (r < 9) return 8'(r);
    if (r < 27) return 8'(r + 5);
    return 8'(r + 6);
  endfunction

  function automatic logic [7:0] space_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'(8'h09 + r);
  endfunction

  task automatic send_request(input logic [7:0] b, input logic first, input logic eot);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    first_byte_i  <= first;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
    if (first) extractions++;
  endtask

  initial begin : stimulus
    int         sent;
    int         len;
    int         shape;
    int         pick;
    int         i;
    logic       cut;
    logic [7:0] b;
    logic [7:0] body[$];
    in_valid_i    <= 1'b0;
    data_byte_i   <= 8'h00;
    first_byte_i  <= 1'b0;
    end_of_text_i <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A byte before any extraction is ignored, then whitespace-first tokens.
    send_request("x", 1'b0, 1'b0);
    send_request(8'h20, 1'b1, 1'b0);
    send_request(8'h0D, 1'b1, 1'b1);
    send_request("a", 1'b1, 1'b0);
    send_request("b", 1'b0, 1'b0);
    send_request(8'h09, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b1);
    // Quoted text: lone opening quote at end of text, escapes, closing quote.
    send_request(qtu_pkg::CH_QUOTE, 1'b1, 1'b1);
    send_request(qtu_pkg::CH_QUOTE, 1'b1, 1'b0);
    send_request(qtu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    send_request(qtu_pkg::CH_QUOTE, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(qtu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    send_request("z", 1'b0, 1'b0);
    send_request(qtu_pkg::CH_QUOTE, 1'b0, 1'b0);
    // Text ending after an escaped quote and right after a backslash.
    send_request(qtu_pkg::CH_QUOTE, 1'b1, 1'b0);
    send_request(qtu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    send_request(qtu_pkg::CH_QUOTE, 1'b0, 1'b1);
    send_request(qtu_pkg::CH_QUOTE, 1'b1, 1'b0);
    send_request(qtu_pkg::CH_BACKSLASH, 1'b0, 1'b1);
    // A new start abandons the running token; a byte after the finish is ignored.
    send_request("q", 1'b1, 1'b0);
    send_request("r", 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request("y", 1'b0, 1'b1);

    sent = 0;
    while (sent < 250) begin
      shape = $urandom_range(0, 9);
      if (shape < 4) begin
        len = $urandom_range(1, 8);
        cut = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++) send_request(solid_byte(), i == 0, cut && i == len - 1);
        sent += len;
        if (!cut) begin
          send_request(space_byte(), 1'b0, 1'($urandom_range(0, 1)));
          sent++;
        end
      end else if (shape < 8) begin
        len = $urandom_range(0, 8);
        cut = ($urandom_range(0, 5) == 0);
        body.delete();
        for (i = 0; i < len; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) begin
            body.push_back(qtu_pkg::CH_BACKSLASH);
            body.push_back(qtu_pkg::CH_QUOTE);
          end else if (pick == 2) begin
            body.push_back(qtu_pkg::CH_BACKSLASH);
            body.push_back(8'($urandom_range(0, 255)));
          end else begin
            b = 8'($urandom_range(0, 255));
            body.push_back((b == qtu_pkg::CH_QUOTE) ? 8'h22 : b);
          end
        end
        if (!cut) body.push_back(qtu_pkg::CH_QUOTE);
        send_request(qtu_pkg::CH_QUOTE, 1'b1, cut && body.size() == 0);
        foreach (body[k]) send_request(body[k], 1'b0, cut && k == body.size() - 1);
        sent += 1 + body.size();
      end else if (shape == 8) begin
        send_request(space_byte(), 1'b1, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // Broken sequence: random bytes, cut short by the next start.
        send_request(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
        len = $urandom_range(0, 4);
        for (i = 0; i < len; i++) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        sent += 1 + len;
      end
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) begin
          send_request(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    $display("Sent %0d text bytes in %0d extractions: quoted, bare, cut short and abandoned.",
             bytes_sent, extractions);
    $display("Compared %0d results under bursty input and changing receiver stalls.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/qtu_pkg.sv
src/qtu_front.sv
src/qtu_queue.sv
src/qtu_back.sv
src/quoted_token_unquoter.sv
src/qtu_checker.sv
sim/qtu_checker.sv
sim/quoted_token_unquoter_tb.sv
